// ----- hw/rtl/drive_command_line_parser_defines.svh -----
// Assertion macros for the drive command line parser.
`ifndef DRIVE_COMMAND_LINE_PARSER_DEFINES_SVH
`define DRIVE_COMMAND_LINE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DCLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define DCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DCLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/dclp_pkg.sv -----
// Types and constants for the drive command line parser.
`timescale 1ns / 1ps

package dclp_pkg;

    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SEP    = 8'd59;
    localparam logic [7:0] CH_IGNORE = 8'd255;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_W      = 8'd119;
    localparam logic [7:0] CH_A      = 8'd97;
    localparam logic [7:0] CH_S      = 8'd115;
    localparam logic [7:0] CH_D      = 8'd100;

    localparam logic [18:0] MAG_MAX  = 19'd32767;
    localparam logic [18:0] RADIX    = 19'd10;

    localparam logic [2:0] FIELD_DIR  = 3'd1;
    localparam logic [2:0] FIELD_SPD  = 3'd2;
    localparam logic [2:0] FIELD_GUN  = 3'd4;
    localparam logic [2:0] FIELD_SAT  = 3'd5;

    localparam logic [2:0] MOTION_NONE     = 3'd0;
    localparam logic [2:0] MOTION_FORWARD  = 3'd1;
    localparam logic [2:0] MOTION_LEFT     = 3'd2;
    localparam logic [2:0] MOTION_BACKWARD = 3'd3;
    localparam logic [2:0] MOTION_RIGHT    = 3'd4;
    localparam logic [2:0] MOTION_STOP     = 3'd5;

    typedef enum logic [1:0] {
        PH_SIGN   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

endpackage

// ----- hw/rtl/drive_command_line_parser.sv -----
// Drive command line parser: serial bytes in, one decoded command per line out.
`timescale 1ns / 1ps
`include "drive_command_line_parser_defines.svh"

// Accepts one byte per cycle. Each byte is folded into the line state in the
// cycle it is accepted; a carriage return loads the result register, so the
// command appears on the m_ side in the cycle after its carriage return. s_ready
// drops only while a result waits in the result register and m_ready is low.
// Lines of dir;speed;fire;gunpos keep at most LINE_MAX characters; the rest
// are dropped and reported through m_overflow. Byte 255 is ignored.
module drive_command_line_parser #(
    parameter int LINE_MAX = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_motion,
    output logic signed [15:0]  m_left_speed,
    output logic signed [15:0]  m_right_speed,
    output logic                m_busy_res,
    output logic signed [15:0]  m_fire_value,
    output logic signed [15:0]  m_gun_position,
    output logic                m_ack,
    output logic                m_overflow
);
    import dclp_pkg::*;

    localparam int CW = $clog2(LINE_MAX + 1);
    localparam logic [CW-1:0] LINE_LIMIT = CW'(LINE_MAX);

    logic [2:0]         field_number_reg, field_number_next;
    logic               inside_token_reg, inside_token_next;
    logic [7:0]         direction_first_reg, direction_first_next;
    logic               direction_long_reg, direction_long_next;
    phase_t             number_phase_reg, number_phase_next;
    logic               negative_sign_reg, negative_sign_next;
    logic signed [15:0] field_values_reg [3];
    logic signed [15:0] field_values_next [3];
    logic [CW-1:0]      line_count_reg, line_count_next;
    logic               busy_flag_reg, busy_flag_next;
    logic               overflow_seen_reg, overflow_seen_next;
    logic               m_valid_reg, m_valid_next;

    logic [2:0]         motion_reg;
    logic signed [15:0] left_speed_reg, right_speed_reg;
    logic               busy_res_reg;
    logic signed [15:0] fire_value_reg, gun_position_reg;
    logic               ack_reg;
    logic               overflow_reg;

    logic               s_fire;
    logic               is_cr;
    logic               load_result;
    logic [2:0]         motion_c;
    logic signed [15:0] ls_c, rs_c;

    assign s_ready     = !m_valid_reg || m_ready;
    assign s_fire      = s_valid && s_ready;
    assign is_cr       = (s_rx_byte == CH_CR);
    assign load_result = s_fire && is_cr;

    // Decode the finished line.
    always_comb begin
        motion_c = MOTION_NONE;
        ls_c     = 16'sd0;
        rs_c     = 16'sd0;
        if (field_number_reg >= FIELD_DIR && !direction_long_reg) begin
            unique case (direction_first_reg)
                CH_W: begin
                    motion_c = MOTION_FORWARD;
                    ls_c     = field_values_reg[0];
                    rs_c     = field_values_reg[0];
                end
                CH_A: begin
                    motion_c = MOTION_LEFT;
                    ls_c     = -field_values_reg[0];
                    rs_c     = field_values_reg[0];
                end
                CH_S: begin
                    motion_c = MOTION_BACKWARD;
                    ls_c     = -field_values_reg[0];
                    rs_c     = -field_values_reg[0];
                end
                CH_D: begin
                    motion_c = MOTION_RIGHT;
                    ls_c     = field_values_reg[0];
                    rs_c     = -field_values_reg[0];
                end
                CH_ZERO: begin
                    motion_c = MOTION_STOP;
                end
                default: begin
                    motion_c = MOTION_NONE;
                end
            endcase
        end
    end

    // Fold one byte into the line state.
    always_comb begin
        logic [2:0]         fn;
        logic [1:0]         slot;
        logic               digit;
        logic signed [15:0] cur;
        logic signed [15:0] mag16;
        logic [14:0]        mag;
        logic [18:0]        acc;
        logic [14:0]        sat;

        field_number_next    = field_number_reg;
        inside_token_next    = inside_token_reg;
        direction_first_next = direction_first_reg;
        direction_long_next  = direction_long_reg;
        number_phase_next    = number_phase_reg;
        negative_sign_next   = negative_sign_reg;
        field_values_next    = field_values_reg;
        line_count_next      = line_count_reg;
        busy_flag_next       = busy_flag_reg;
        overflow_seen_next   = overflow_seen_reg;

        fn    = field_number_reg;
        slot  = 2'd0;
        digit = (s_rx_byte >= CH_ZERO) && (s_rx_byte <= CH_NINE);
        cur   = 16'sd0;
        mag16 = 16'sd0;
        mag   = 15'd0;
        acc   = 19'd0;
        sat   = 15'd0;

        if (s_fire && s_rx_byte != CH_IGNORE) begin
            if (!is_cr) begin
                if (line_count_reg >= LINE_LIMIT) begin
                    overflow_seen_next = 1'b1;
                end else begin
                    line_count_next = line_count_reg + CW'(1);
                    if (s_rx_byte == CH_SEP) begin
                        inside_token_next  = 1'b0;
                        number_phase_next  = PH_SIGN;
                        negative_sign_next = 1'b0;
                    end else begin
                        if (!inside_token_reg) begin
                            inside_token_next = 1'b1;
                            if (fn < FIELD_SAT) begin
                                fn = fn + 3'd1;
                            end
                            field_number_next = fn;
                            if (fn == FIELD_DIR) begin
                                direction_first_next = s_rx_byte;
                            end
                        end else if (fn == FIELD_DIR) begin
                            direction_long_next = 1'b1;
                        end

                        if (fn >= FIELD_SPD && fn <= FIELD_GUN) begin
                            slot  = 2'(fn - FIELD_SPD);
                            cur   = field_values_reg[slot];
                            mag16 = negative_sign_reg ? -cur : cur;
                            mag   = mag16[14:0];
                            acc   = 19'(mag) * RADIX + 19'(s_rx_byte[3:0]);
                            if (acc > MAG_MAX) begin
                                sat = MAG_MAX[14:0];
                            end else begin
                                sat = acc[14:0];
                            end
                            case (number_phase_reg)
                                PH_SIGN: begin
                                    if (s_rx_byte == CH_MINUS) begin
                                        negative_sign_next = 1'b1;
                                        number_phase_next  = PH_DIGITS;
                                    end else if (digit) begin
                                        number_phase_next = PH_DIGITS;
                                        if (acc > MAG_MAX) begin
                                            overflow_seen_next = 1'b1;
                                        end
                                        field_values_next[slot] = negative_sign_reg ?
                                            -$signed({1'b0, sat}) : $signed({1'b0, sat});
                                    end else begin
                                        number_phase_next = PH_DONE;
                                    end
                                end
                                PH_DIGITS: begin
                                    if (digit) begin
                                        if (acc > MAG_MAX) begin
                                            overflow_seen_next = 1'b1;
                                        end
                                        field_values_next[slot] = negative_sign_reg ?
                                            -$signed({1'b0, sat}) : $signed({1'b0, sat});
                                    end else begin
                                        number_phase_next = PH_DONE;
                                    end
                                end
                                default: begin
                                    number_phase_next = number_phase_reg;
                                end
                            endcase
                        end
                    end
                end
            end else begin
                if (motion_c >= MOTION_FORWARD && motion_c <= MOTION_RIGHT) begin
                    busy_flag_next = 1'b1;
                end else if (motion_c == MOTION_STOP) begin
                    busy_flag_next = 1'b0;
                end
                field_number_next    = 3'd0;
                inside_token_next    = 1'b0;
                direction_first_next = 8'd0;
                direction_long_next  = 1'b0;
                number_phase_next    = PH_SIGN;
                negative_sign_next   = 1'b0;
                field_values_next[0] = 16'sd0;
                field_values_next[1] = 16'sd0;
                field_values_next[2] = 16'sd0;
                line_count_next      = '0;
                overflow_seen_next   = 1'b0;
            end
        end
    end

    always_comb begin
        if (load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_number_reg    <= 3'd0;
            inside_token_reg    <= 1'b0;
            direction_first_reg <= 8'd0;
            direction_long_reg  <= 1'b0;
            number_phase_reg    <= PH_SIGN;
            negative_sign_reg   <= 1'b0;
            field_values_reg[0] <= 16'sd0;
            field_values_reg[1] <= 16'sd0;
            field_values_reg[2] <= 16'sd0;
            line_count_reg      <= '0;
            busy_flag_reg       <= 1'b0;
            overflow_seen_reg   <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            field_number_reg    <= field_number_next;
            inside_token_reg    <= inside_token_next;
            direction_first_reg <= direction_first_next;
            direction_long_reg  <= direction_long_next;
            number_phase_reg    <= number_phase_next;
            negative_sign_reg   <= negative_sign_next;
            field_values_reg    <= field_values_next;
            line_count_reg      <= line_count_next;
            busy_flag_reg       <= busy_flag_next;
            overflow_seen_reg   <= overflow_seen_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    // Load the result register on carriage return.
    always_ff @(posedge aclk) begin
        if (load_result) begin
            motion_reg       <= motion_c;
            left_speed_reg   <= ls_c;
            right_speed_reg  <= rs_c;
            busy_res_reg     <= busy_flag_next;
            fire_value_reg   <= field_values_reg[1];
            gun_position_reg <= field_values_reg[2];
            ack_reg          <= (motion_c >= MOTION_FORWARD) && (motion_c <= MOTION_RIGHT);
            overflow_reg     <= overflow_seen_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_motion       = motion_reg;
    assign m_left_speed   = left_speed_reg;
    assign m_right_speed  = right_speed_reg;
    assign m_busy_res     = busy_res_reg;
    assign m_fire_value   = fire_value_reg;
    assign m_gun_position = gun_position_reg;
    assign m_ack          = ack_reg;
    assign m_overflow     = overflow_reg;

    `DCLP_ASSERT_NEXT(a_cr_gives_result, aclk, aresetn, load_result, m_valid)
    `DCLP_ASSERT_NEXT(a_no_spurious_result, aclk, aresetn, s_fire && !is_cr && s_ready && (!m_valid || m_ready), !m_valid)
    `DCLP_ASSERT_IMPLY(a_ack_implies_busy, aclk, aresetn, m_valid && m_ack, m_busy_res)
    `DCLP_ASSERT_IMPLY(a_idle_motion_no_speed, aclk, aresetn, m_valid && (m_motion == MOTION_NONE || m_motion == MOTION_STOP), m_left_speed == 16'sd0 && m_right_speed == 16'sd0)
    `DCLP_ASSERT_IMPLY(a_line_count_bound, aclk, aresetn, 1'b1, line_count_reg <= LINE_LIMIT)

endmodule
